// File: rtl/core/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 32;
   localparam int HELD_W       = 5;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef struct packed {
      logic                      op;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] popped_value;
      logic                      popped_valid;
      logic                      rejected;
      logic                      is_empty;
      logic [HELD_W-1:0]         held_count;
   } rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

// File: rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue.
`timescale 1ns / 1ps

// Keeps up to CAPACITY signed 32-bit values in ascending order in a row of
// compare-and-shift cells. A push (op 0) inserts its value behind any equal
// values; a pop (op 1) removes and returns the smallest. Every request yields
// one response with the popped value, a rejected flag (push when full, pop
// when empty), the count after the request (low 5 bits) and an empty flag.
// A request is first registered, then applied across all cells at once while
// the response register is loaded, so a new request is taken only after the
// last one is applied; a stalled response holds the registered request in the
// execute step until the response register is free.
module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   spq_cells #(
      .CAPACITY (CAPACITY)
   ) u_cells (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// File: rtl/core/spq_ctrl.sv
// Controller state machine for the sorted priority queue.
`timescale 1ns / 1ps

module spq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::cmd_type cmd
);
   import spq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // the response register can take a new result this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.capture  = 1'b0;
      cmd.execute  = 1'b0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.execute = out_free;
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/core/spq_cells.sv
// Datapath: request register, row of sorted compare-and-shift cells, count and response.
`timescale 1ns / 1ps

module spq_cells #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  spq_pkg::cmd_type cmd,
   input  spq_pkg::req_type req_data,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   req_type                   req_ff;
   rsp_type                   rsp_ff, rsp_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [VALUE_W-1:0] entry_ff [CAPACITY];
   logic signed [VALUE_W-1:0] entry_in [CAPACITY];
   logic [CAPACITY-1:0]       gt;
   logic [CAPACITY-1:0]       at_end;
   logic                      is_full, is_none, push_ok, pop_ok;
   logic [CNT_W+HELD_W-1:0]   held_wide;

   assign is_full = (count_ff == CNT_W'(CAPACITY));
   assign is_none = (count_ff == '0);
   assign push_ok = (req_ff.op == OP_PUSH) && !is_full;
   assign pop_ok  = (req_ff.op == OP_POP) && !is_none;

   // each cell compares its own entry; held entries above the new value shift up
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign gt[i]     = (CNT_W'(i) < count_ff) && (entry_ff[i] > req_ff.value);
      assign at_end[i] = (CNT_W'(i) == count_ff);

      if (i == 0) begin : g_first
         always_comb begin
            entry_in[i] = entry_ff[i];
            if (push_ok) begin
               if (gt[i] || at_end[i]) entry_in[i] = req_ff.value;
            end else if (pop_ok) begin
               if (CAPACITY > 1) entry_in[i] = entry_ff[(CAPACITY > 1) ? 1 : 0];
            end
         end
      end else begin : g_rest
         always_comb begin
            entry_in[i] = entry_ff[i];
            if (push_ok) begin
               if (gt[i] || at_end[i]) entry_in[i] = gt[i-1] ? entry_ff[i-1] : req_ff.value;
            end else if (pop_ok) begin
               if (i < CAPACITY - 1) entry_in[i] = entry_ff[(i < CAPACITY - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push_ok)     count_in = count_ff + CNT_W'(1);
      else if (pop_ok) count_in = count_ff - CNT_W'(1);

      held_wide = {{HELD_W{1'b0}}, count_in};

      rsp_in.popped_value = pop_ok ? entry_ff[0] : '0;
      rsp_in.popped_valid = pop_ok;
      rsp_in.rejected     = !push_ok && !pop_ok;
      rsp_in.is_empty     = (count_in == '0);
      rsp_in.held_count   = held_wide[HELD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.execute) begin
         rsp_ff   <= rsp_in;
         entry_ff <= entry_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
